// ===== hw/rtl/tournament_barrier_node_macros.svh =====
// Assertion macros used by the port-level checker of the barrier node.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef TOURNAMENT_BARRIER_NODE_MACROS_SVH
`define TOURNAMENT_BARRIER_NODE_MACROS_SVH

// same-cycle implication
`define TBN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tbn_pkg.sv =====
// Types, codes and role/opponent functions of the tournament barrier node.
// Depends on nothing; used by the controller, datapath, top and checker.
package tbn_pkg;

    localparam int MaxNodes  = 64;
    localparam int MaxRounds = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_RANK   = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

    // input event codes
    localparam logic [1:0] FUNC_ENTER   = 2'd0;
    localparam logic [1:0] FUNC_ARRIVAL = 2'd1;
    localparam logic [1:0] FUNC_WAKEUP  = 2'd2;

    // result action codes
    localparam logic [1:0] ACT_ARRIVAL    = 2'd0;
    localparam logic [1:0] ACT_WAKEUP     = 2'd1;
    localparam logic [1:0] ACT_RELEASE    = 2'd2;
    localparam logic [1:0] ACT_UNEXPECTED = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_ARR  = 2'd1,
        PH_WAIT_WAKE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RL_BYE      = 2'd0,
        RL_WINNER   = 2'd1,
        RL_LOSER    = 2'd2,
        RL_CHAMPION = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DISP = 2'd1,
        CS_UP   = 2'd2,
        CS_DOWN = 2'd3
    } t_ctrl_state;

    typedef enum logic [2:0] {
        DK_BAD   = 3'd0,
        DK_ENTER = 3'd1,
        DK_WIN   = 3'd2,
        DK_CHAMP = 3'd3,
        DK_WAKE  = 3'd4
    } t_disp_kind;

    typedef enum logic [2:0] {
        WO_HOLD    = 3'd0,
        WO_ONE     = 3'd1,
        WO_CUR     = 3'd2,
        WO_CUR_INC = 3'd3,
        WO_CUR_DEC = 3'd4,
        WO_TOP     = 3'd5,
        WO_INC     = 3'd6,
        WO_DEC     = 3'd7
    } t_walk_op;

    typedef enum logic [1:0] {
        PO_HOLD      = 2'd0,
        PO_WAIT_ARR  = 2'd1,
        PO_WAIT_WAKE = 2'd2,
        PO_IDLE      = 2'd3
    } t_phase_op;

    typedef struct packed {
        logic       load_in;
        t_walk_op   walk_op;
        t_phase_op  phase_op;
        logic       emit;
        logic [1:0] action;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        t_disp_kind disp_kind;
        t_role      walk_role;
        logic       walk_over_top;
        logic       walk_zero;
        logic       out_free;
    } t_dp_sts;

    // role of a node in round rnd; span 2^rnd, half 2^(rnd-1)
    function automatic t_role role_of(input logic [5:0] rank, input logic [6:0] count,
                                      input logic [2:0] rnd);
        logic [7:0] span;
        logic [7:0] half;
        logic [7:0] eff;
        logic [7:0] rem;
        logic [7:0] rank_w;
        t_role      res;
        span   = 8'd1 << rnd;
        half   = span >> 1;
        eff    = (count > 7'(MaxNodes)) ? 8'(MaxNodes) : {1'b0, count};
        rank_w = {2'b00, rank};
        rem    = rank_w & (span - 8'd1);
        if (rank == 6'd0 && span >= eff) begin
            res = RL_CHAMPION;
        end else if (rem == 8'd0 && (rank_w + half) < eff && span < eff) begin
            res = RL_WINNER;
        end else if (rem == half) begin
            res = RL_LOSER;
        end else begin
            res = RL_BYE;
        end
        return res;
    endfunction

    function automatic logic [5:0] opponent_of(input logic [5:0] rank, input logic [2:0] rnd,
                                               input t_role role);
        logic [7:0] half;
        logic [7:0] sum;
        half = 8'd1 << (rnd - 3'd1);
        if (role == RL_LOSER) begin
            sum = {2'b00, rank} - half;
        end else begin
            sum = {2'b00, rank} + half;
        end
        return sum[5:0];
    endfunction

endpackage

// ===== hw/rtl/tournament_barrier_node.sv =====
// Tournament barrier node. An event is accepted and dispatched, then walks up
// round by round until a round stops it or it passes the top, then walks down
// round by round and ends with the release (round_count is clamped to 6); a
// stalled output holds back each result until it is taken.
// One event is worked at a time; results leave through a one-entry register.
// Synchronous active-low reset: rank 0, count 1, rounds 0, phase idle.
module tournament_barrier_node (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [1:0] func, [7:2] from_node
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] action, [7:2] dest_node
    output logic       o_m_axis_tlast
);

    tbn_pkg::t_dp_cmd cmd;
    tbn_pkg::t_dp_sts sts;

    tbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tbn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== hw/rtl/tbn_ctrl.sv =====
// Sequencer of the barrier node: dispatch, walk-up and wakeup walk-down.
// Depends on tbn_pkg; drives the datapath by command and reads its status.
module tbn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tbn_pkg::t_dp_sts i_sts,
    output tbn_pkg::t_dp_cmd o_cmd
);

    tbn_pkg::t_ctrl_state r_state;
    tbn_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbn_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.walk_op  = tbn_pkg::WO_HOLD;
        o_cmd.phase_op = tbn_pkg::PO_HOLD;
        o_cmd.emit     = 1'b0;
        o_cmd.action   = tbn_pkg::ACT_UNEXPECTED;
        o_cmd.last     = 1'b0;
        case (r_state)
            tbn_pkg::CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = tbn_pkg::CS_DISP;
                end
            end
            tbn_pkg::CS_DISP: begin
                case (i_sts.disp_kind)
                    tbn_pkg::DK_ENTER: begin
                        o_cmd.walk_op = tbn_pkg::WO_ONE;
                        n_state       = tbn_pkg::CS_UP;
                    end
                    tbn_pkg::DK_WIN: begin
                        o_cmd.walk_op = tbn_pkg::WO_CUR_INC;
                        n_state       = tbn_pkg::CS_UP;
                    end
                    tbn_pkg::DK_CHAMP: begin
                        o_cmd.walk_op = tbn_pkg::WO_CUR;
                        n_state       = tbn_pkg::CS_DOWN;
                    end
                    tbn_pkg::DK_WAKE: begin
                        o_cmd.walk_op = tbn_pkg::WO_CUR_DEC;
                        n_state       = tbn_pkg::CS_DOWN;
                    end
                    default: begin
                        // bad event: one unexpected result, state untouched
                        if (i_sts.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.action = tbn_pkg::ACT_UNEXPECTED;
                            o_cmd.last   = 1'b1;
                            n_state      = tbn_pkg::CS_IDLE;
                        end
                    end
                endcase
            end
            tbn_pkg::CS_UP: begin
                if (i_sts.walk_over_top) begin
                    // no round stopped the walk: wake down from the top
                    o_cmd.walk_op = tbn_pkg::WO_TOP;
                    n_state       = tbn_pkg::CS_DOWN;
                end else begin
                    case (i_sts.walk_role)
                        tbn_pkg::RL_WINNER, tbn_pkg::RL_CHAMPION: begin
                            o_cmd.phase_op = tbn_pkg::PO_WAIT_ARR;
                            n_state        = tbn_pkg::CS_IDLE;
                        end
                        tbn_pkg::RL_LOSER: begin
                            if (i_sts.out_free) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.action   = tbn_pkg::ACT_ARRIVAL;
                                o_cmd.last     = 1'b1;
                                o_cmd.phase_op = tbn_pkg::PO_WAIT_WAKE;
                                n_state        = tbn_pkg::CS_IDLE;
                            end
                        end
                        default: begin
                            o_cmd.walk_op = tbn_pkg::WO_INC;
                        end
                    endcase
                end
            end
            tbn_pkg::CS_DOWN: begin
                if (i_sts.walk_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.action   = tbn_pkg::ACT_RELEASE;
                        o_cmd.last     = 1'b1;
                        o_cmd.phase_op = tbn_pkg::PO_IDLE;
                        n_state        = tbn_pkg::CS_IDLE;
                    end
                end else if (i_sts.walk_role == tbn_pkg::RL_WINNER ||
                             i_sts.walk_role == tbn_pkg::RL_CHAMPION) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.action  = tbn_pkg::ACT_WAKEUP;
                        o_cmd.walk_op = tbn_pkg::WO_DEC;
                    end
                end else begin
                    o_cmd.walk_op = tbn_pkg::WO_DEC;
                end
            end
            default: begin
                n_state = tbn_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tbn_dp.sv =====
// Datapath of the barrier node: config, phase/round state, walk counter,
// role decode and output register. Depends on tbn_pkg.
module tbn_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [6:0]       i_cfg_wdata,
    input  logic [7:0]       i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_data,
    output logic             o_out_last,
    input  tbn_pkg::t_dp_cmd i_cmd,
    output tbn_pkg::t_dp_sts o_sts
);

    logic [5:0]      r_rank;
    logic [6:0]      r_count;
    logic [2:0]      r_rounds;
    logic [1:0]      r_func;
    logic [5:0]      r_from;
    tbn_pkg::t_phase r_phase;
    logic [2:0]      r_cur;
    logic [2:0]      r_walk;
    logic [2:0]      n_walk;
    logic            r_out_valid;
    logic [1:0]      r_out_action;
    logic [5:0]      r_out_dest;
    logic            r_out_last;

    logic [2:0]      top;
    tbn_pkg::t_role  cur_role;
    logic [5:0]      cur_opp;
    tbn_pkg::t_role  walk_role;
    logic [5:0]      walk_opp;
    logic            win_like;
    tbn_pkg::t_disp_kind disp_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= '0;
            r_count  <= 7'd1;
            r_rounds <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tbn_pkg::CFG_NODE_RANK:   r_rank   <= i_cfg_wdata[5:0];
                tbn_pkg::CFG_NODE_COUNT:  r_count  <= i_cfg_wdata;
                tbn_pkg::CFG_ROUND_COUNT: r_rounds <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign top = (r_rounds > 3'(tbn_pkg::MaxRounds)) ? 3'(tbn_pkg::MaxRounds) : r_rounds;

    assign cur_role  = tbn_pkg::role_of(r_rank, r_count, r_cur);
    assign cur_opp   = tbn_pkg::opponent_of(r_rank, r_cur, cur_role);
    assign walk_role = tbn_pkg::role_of(r_rank, r_count, r_walk);
    assign walk_opp  = tbn_pkg::opponent_of(r_rank, r_walk, walk_role);
    assign win_like  = (cur_role == tbn_pkg::RL_WINNER) || (cur_role == tbn_pkg::RL_CHAMPION);

    // classify the latched event against the waiting state
    always_comb begin
        disp_kind = tbn_pkg::DK_BAD;
        if (r_func == tbn_pkg::FUNC_ENTER && r_phase == tbn_pkg::PH_IDLE) begin
            disp_kind = tbn_pkg::DK_ENTER;
        end else if (r_func == tbn_pkg::FUNC_ARRIVAL && r_phase == tbn_pkg::PH_WAIT_ARR &&
                     r_cur != 3'd0 && win_like && r_from == cur_opp) begin
            disp_kind = (cur_role == tbn_pkg::RL_CHAMPION) ? tbn_pkg::DK_CHAMP
                                                           : tbn_pkg::DK_WIN;
        end else if (r_func == tbn_pkg::FUNC_WAKEUP && r_phase == tbn_pkg::PH_WAIT_WAKE &&
                     r_cur != 3'd0 && cur_role == tbn_pkg::RL_LOSER && r_from == cur_opp) begin
            disp_kind = tbn_pkg::DK_WAKE;
        end
    end

    assign o_sts.disp_kind     = disp_kind;
    assign o_sts.walk_role     = walk_role;
    assign o_sts.walk_over_top = r_walk > top;
    assign o_sts.walk_zero     = r_walk == 3'd0;
    assign o_sts.out_free      = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.walk_op)
            tbn_pkg::WO_ONE:     n_walk = 3'd1;
            tbn_pkg::WO_CUR:     n_walk = r_cur;
            tbn_pkg::WO_CUR_INC: n_walk = r_cur + 3'd1;
            tbn_pkg::WO_CUR_DEC: n_walk = r_cur - 3'd1;
            tbn_pkg::WO_TOP:     n_walk = top;
            tbn_pkg::WO_INC:     n_walk = r_walk + 3'd1;
            tbn_pkg::WO_DEC:     n_walk = r_walk - 3'd1;
            default:             n_walk = r_walk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        if (i_cmd.load_in) begin
            r_func <= i_in_data[1:0];
            r_from <= i_in_data[7:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tbn_pkg::PH_IDLE;
            r_cur   <= '0;
        end else begin
            case (i_cmd.phase_op)
                tbn_pkg::PO_WAIT_ARR: begin
                    r_phase <= tbn_pkg::PH_WAIT_ARR;
                    r_cur   <= r_walk;
                end
                tbn_pkg::PO_WAIT_WAKE: begin
                    r_phase <= tbn_pkg::PH_WAIT_WAKE;
                    r_cur   <= r_walk;
                end
                tbn_pkg::PO_IDLE: begin
                    r_phase <= tbn_pkg::PH_IDLE;
                    r_cur   <= '0;
                end
                default: ;
            endcase
        end
    end

    // single result slot; sends carry the walk round's opponent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_action <= i_cmd.action;
            r_out_last   <= i_cmd.last;
            r_out_dest   <= (i_cmd.action == tbn_pkg::ACT_ARRIVAL ||
                             i_cmd.action == tbn_pkg::ACT_WAKEUP) ? walk_opp : 6'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_dest, r_out_action};
    assign o_out_last  = r_out_last;

endmodule

// ===== hw/rtl/tbn_checker.sv =====
// Port-level checks of the barrier node, bound to the top level.
// Depends on tbn_pkg and tournament_barrier_node_macros.svh.
`include "tournament_barrier_node_macros.svh"

module tbn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    logic out_ends;

    assign out_ends = o_m_axis_tdata[1:0] == tbn_pkg::ACT_RELEASE ||
                      o_m_axis_tdata[1:0] == tbn_pkg::ACT_UNEXPECTED;

    `TBN_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "result changed while stalled")
    `TBN_ASSERT_IMP(a_end_last, o_m_axis_tvalid && out_ends, o_m_axis_tlast, "release or unexpected result without tlast")
    `TBN_ASSERT_IMP(a_end_dest, o_m_axis_tvalid && out_ends, o_m_axis_tdata[7:2] == 6'd0, "nonzero destination on release or unexpected")
    `TBN_ASSERT_NXT(a_one_item, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second event taken while one is in work")

endmodule

bind tournament_barrier_node tbn_checker u_tbn_checker (.*);
